FILE: hw/rtl/interval_coverage_accumulator_macros.svh
// Assertion macros for the interval coverage accumulator checker.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef INTERVAL_COVERAGE_ACCUMULATOR_MACROS_SVH
`define INTERVAL_COVERAGE_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define ICA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ica: same-cycle check failed");

// next-cycle implication
`define ICA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ica: next-cycle check failed");

`endif

FILE: hw/rtl/ica_pkg.sv
// Shared constants, types and helpers for the interval coverage accumulator.
// No dependencies.
package ica_pkg;

  localparam int unsigned MAX_POSITIONS = 32768;
  localparam int unsigned COUNT_BITS    = 16;

  localparam int unsigned ADDR_W  = $clog2(MAX_POSITIONS);
  localparam int unsigned POS_W   = 15;   // item position fields
  localparam int unsigned GLEN_W  = 16;   // genome_length register
  localparam int unsigned COUNT_W = 16;   // coverage_count field
  localparam int unsigned CMP_W   = (ADDR_W + 1 > GLEN_W) ? ADDR_W + 1 : GLEN_W;
  localparam int unsigned WIDE_W  = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [GLEN_W-1:0] GLEN_RESET = GLEN_W'(32768);

  typedef struct packed {
    logic              ren;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              clr;
  } mem_req_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(c);
    if (w > WIDE_W'({COUNT_W{1'b1}})) begin
      return '1;
    end
    return COUNT_W'(w);
  endfunction

endpackage

FILE: hw/rtl/ica_store.sv
// Coverage counter memory with its saturating read-modify-write incrementer.
// Depends on ica_pkg.
module ica_store
  import ica_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [COUNT_BITS-1:0] rdata_o
);

  logic [COUNT_BITS-1:0] mem [MAX_POSITIONS];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [COUNT_BITS-1:0] wdata;

  // write data comes from the previous read, or zero on a clear sweep
  assign wdata = req_i.clr ? '0 : sat_inc(rdata_q);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= wdata;
    end
    if (req_i.ren) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ica_ctrl.sv
// Sequencer: decodes items, walks add intervals, sweeps clears, forms results.
// Depends on ica_pkg; drives ica_store.
module ica_ctrl
  import ica_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [POS_W-1:0]      start_pos_i,
  input  logic [POS_W-1:0]      end_pos_i,
  input  logic [POS_W-1:0]      query_pos_i,
  input  logic [GLEN_W-1:0]     genome_length_i,
  input  logic [COUNT_BITS-1:0] rdata_i,
  output mem_req_t              req_o,
  output logic                  done_o,
  output logic [COUNT_W-1:0]    coverage_count_o,
  output logic                  out_of_range_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_QRY   = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_POSITIONS - 1);

  logic [2:0]         state_q, state_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic               pend_q, pend_d;
  logic               done_q, done_d;
  logic [ADDR_W-1:0]  last_q, last_d;
  logic [ADDR_W-1:0]  wa_q, wa_d;
  logic               flag_q, flag_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               oor_q, oor_d;

  logic [CMP_W-1:0] len, s_w, e_w, q_w, e_clamp;

  always_comb begin
    len = (CMP_W'(genome_length_i) > CMP_W'(MAX_POSITIONS)) ? CMP_W'(MAX_POSITIONS)
                                                            : CMP_W'(genome_length_i);
    s_w = CMP_W'(start_pos_i);
    e_w = CMP_W'(end_pos_i);
    q_w = CMP_W'(query_pos_i);
    e_clamp = (e_w >= len) ? len - 1'b1 : e_w;
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    pend_d  = 1'b0;
    done_d  = 1'b0;
    last_d  = last_q;
    wa_d    = wa_q;
    flag_d  = flag_q;
    cnt_d   = cnt_q;
    oor_d   = oor_q;
    req_o   = '0;
    // write-back of the read issued in the previous cycle
    req_o.we    = pend_q;
    req_o.waddr = wa_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (action_i)
            ACT_ADD: begin
              if (s_w > e_w) begin
                done_d = 1'b1;
                cnt_d  = '0;
                oor_d  = 1'b0;
              end else if (s_w >= len) begin
                done_d = 1'b1;
                cnt_d  = '0;
                oor_d  = 1'b1;
              end else begin
                pos_d   = s_w[ADDR_W-1:0];
                last_d  = e_clamp[ADDR_W-1:0];
                flag_d  = (e_w >= len);
                state_d = ST_ADD;
              end
            end
            ACT_QUERY: begin
              if (q_w >= len) begin
                done_d = 1'b1;
                cnt_d  = '0;
                oor_d  = 1'b1;
              end else begin
                req_o.ren   = 1'b1;
                req_o.raddr = q_w[ADDR_W-1:0];
                state_d     = ST_QRY;
              end
            end
            ACT_CLEAR: begin
              pos_d   = '0;
              state_d = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        // read this position while the previous one is written back
        req_o.ren   = 1'b1;
        req_o.raddr = pos_q;
        pend_d      = 1'b1;
        wa_d        = pos_q;
        if (pos_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        done_d  = 1'b1;
        cnt_d   = '0;
        oor_d   = flag_q;
        state_d = ST_IDLE;
      end
      ST_QRY: begin
        done_d  = 1'b1;
        cnt_d   = clip_count(rdata_i);
        oor_d   = 1'b0;
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        req_o.we    = 1'b1;
        req_o.waddr = pos_q;
        req_o.clr   = 1'b1;
        if (pos_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;   // clearing pass after reset
      pos_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    wa_q   <= wa_d;
    flag_q <= flag_d;
    cnt_q  <= cnt_d;
    oor_q  <= oor_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign coverage_count_o = cnt_q;
  assign out_of_range_o   = oor_q;

endmodule

FILE: hw/rtl/interval_coverage_accumulator.sv
// Interval coverage accumulator top level: config register, sequencer, store.
// Depends on ica_pkg, ica_ctrl, ica_store.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   command  | start, busy             | action_i, start_pos_i, end_pos_i, query_pos_i
//   result   | done_o (one-cycle)      | coverage_count_o, out_of_range_o
//   config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// An add item keeps busy high while it walks its positions and drains: one counter
// read-modify-write per position through the store's single read and write port.
// Adds that walk nothing, and out-of-range queries, never raise busy; a query in range does.
// Reset and a clear item each sweep the whole store with busy high.
// done_o pulses for one cycle in the first idle cycle after an item's work.
module interval_coverage_accumulator
  import ica_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [POS_W-1:0]   start_pos_i,
  input  logic [POS_W-1:0]   end_pos_i,
  input  logic [POS_W-1:0]   query_pos_i,
  output logic               done_o,
  output logic [COUNT_W-1:0] coverage_count_o,
  output logic               out_of_range_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [GLEN_W-1:0]     glen_q;
  logic                  reg_sel;
  mem_req_t              req;
  logic [COUNT_BITS-1:0] rdata;

  assign pready  = 1'b1;
  assign reg_sel = (paddr == 3'd0);
  assign prdata  = reg_sel ? 32'(glen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glen_q <= GLEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      glen_q <= pwdata[GLEN_W-1:0];
    end
  end

  ica_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .start_pos_i      (start_pos_i),
    .end_pos_i        (end_pos_i),
    .query_pos_i      (query_pos_i),
    .genome_length_i  (glen_q),
    .rdata_i          (rdata),
    .req_o            (req),
    .done_o           (done_o),
    .coverage_count_o (coverage_count_o),
    .out_of_range_o   (out_of_range_o)
  );

  ica_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule

FILE: hw/rtl/ica_checker.sv
// Port-level checks on the interval coverage accumulator, bound to the top.
// Depends on ica_pkg and interval_coverage_accumulator_macros.svh.
`include "interval_coverage_accumulator_macros.svh"

module ica_checker
  import ica_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         action_i,
  input logic [POS_W-1:0]   start_pos_i,
  input logic [POS_W-1:0]   end_pos_i,
  input logic               done_o,
  input logic [COUNT_W-1:0] coverage_count_o,
  input logic               out_of_range_o
);

  // a result only appears once the block is idle again
  `ICA_ASSERT_NOW(a_done_idle, done_o, !busy)
  // flagged results never carry a count
  `ICA_ASSERT_NOW(a_oor_zero, done_o, (!out_of_range_o || coverage_count_o == '0))
  // an empty interval is answered at once, unflagged
  `ICA_ASSERT_NEXT(a_empty_add, (start && !busy && action_i == ACT_ADD && start_pos_i > end_pos_i), (done_o && !out_of_range_o))
  // a clear item sweeps silently
  `ICA_ASSERT_NEXT(a_clear_busy, (start && !busy && action_i == ACT_CLEAR), (busy && !done_o))

endmodule

bind interval_coverage_accumulator ica_checker u_ica_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .action_i         (action_i),
  .start_pos_i      (start_pos_i),
  .end_pos_i        (end_pos_i),
  .done_o           (done_o),
  .coverage_count_o (coverage_count_o),
  .out_of_range_o   (out_of_range_o)
);

FILE: test/tb_interval_coverage_accumulator.sv
// Self-checking testbench for interval_coverage_accumulator: directed table, then random
// phases over several genome lengths, each result checked against its row or a local predictor.
// Depends on ica_pkg and the RTL of interval_coverage_accumulator.
module tb_interval_coverage_accumulator
  import ica_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [2:0]  GLEN_ADDR   = 3'd0;
  localparam logic [2:0]  SPARE_ADDR  = 3'd4;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned POS_TOP     = (1 << POS_W) - 1;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] query_pos;
  } cov_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               flag;
  } cov_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cov_cmd_t    cmd;
    logic        typed;   // expected result written in the row
    cov_result_t want;
    logic [2:0]  addr;
    logic [31:0] wdata;
  } dir_row_t;

  localparam int unsigned N_ROWS = 31;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd0, 15'd0, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'h7FFF, 15'h7FFF, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd0}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'h7FFF}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd5, 15'd3, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd10, 15'd20, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd15}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_UNUSED, 15'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_CLEAR, 15'd0, 15'd0, 15'd0}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd15}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_CFG, '0, 1'b0, '0, GLEN_ADDR, 32'd100},
    '{ROW_ITEM, '{ACT_ADD, 15'd90, 15'd200, 15'd0}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd99}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd100}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd150, 15'd160, 15'd0}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd120, 15'd110, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_CFG, '0, 1'b0, '0, SPARE_ADDR, 32'd5},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd99}, 1'b0, '0, '0, '0},
    '{ROW_CFG, '0, 1'b0, '0, GLEN_ADDR, 32'd1},
    '{ROW_ITEM, '{ACT_ADD, 15'd0, 15'd5, 15'd0}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd0}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd1}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_CFG, '0, 1'b0, '0, GLEN_ADDR, 32'd0},
    '{ROW_ITEM, '{ACT_ADD, 15'd0, 15'd0, 15'd0}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd0}, 1'b1, '{16'd0, 1'b1}, '0, '0},
    '{ROW_CFG, '0, 1'b0, '0, GLEN_ADDR, 32'hFFFF_FFFF},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'h7FFF}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_ADD, 15'd0, 15'h7FFF, 15'd0}, 1'b1, '{16'd0, 1'b0}, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'h7FFF}, 1'b0, '0, '0, '0},
    '{ROW_ITEM, '{ACT_QUERY, 15'd0, 15'd0, 15'd0}, 1'b0, '0, '0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action_i = ACT_ADD;
  logic [POS_W-1:0]   start_pos_i = '0;
  logic [POS_W-1:0]   end_pos_i = '0;
  logic [POS_W-1:0]   query_pos_i = '0;
  logic               done_o;
  logic [COUNT_W-1:0] coverage_count_o;
  logic               out_of_range_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  interval_coverage_accumulator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  bit [COUNT_BITS-1:0] depth_model [MAX_POSITIONS];
  logic [GLEN_W-1:0]   glen_model = GLEN_RESET;
  cov_result_t         awaited [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned window_lo = 0;
  bit          idle_on = 1'b1;
  int unsigned n_adds = 0, n_queries = 0, n_clears = 0, n_lengths = 0;
  int unsigned n_flagged = 0, n_saturated = 0;

  function automatic int unsigned positions_used();
    return (glen_model > MAX_POSITIONS) ? MAX_POSITIONS : int'(glen_model);
  endfunction

  // Applies one item to the predicted store; returns 1 when it yields a result.
  function automatic bit coverage_step(input cov_cmd_t c, output cov_result_t r);
    int unsigned span, hi;
    span = positions_used();
    r = '0;
    case (c.action)
      ACT_ADD: begin
        if (c.first_pos <= c.last_pos) begin
          if (c.first_pos >= span) begin
            r.flag = 1'b1;
          end else begin
            hi = c.last_pos;
            if (hi >= span) begin
              hi = span - 1;
              r.flag = 1'b1;
            end
            for (int unsigned p = c.first_pos; p <= hi; p++) begin
              if (depth_model[p] != '1) depth_model[p] = depth_model[p] + 1'b1;
            end
          end
        end
        return 1'b1;
      end
      ACT_QUERY: begin
        if (c.query_pos >= span) begin
          r.flag = 1'b1;
        end else if (depth_model[c.query_pos] > {COUNT_W{1'b1}}) begin
          r.count = '1;
        end else begin
          r.count = COUNT_W'(depth_model[c.query_pos]);
        end
        return 1'b1;
      end
      ACT_CLEAR: begin
        foreach (depth_model[i]) depth_model[i] = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input int unsigned v);
    return (v > POS_TOP) ? POS_W'(POS_TOP) : POS_W'(v);
  endfunction

  // Mostly in the working window; some near or past the genome end, at either extreme or anywhere.
  function automatic logic [POS_W-1:0] draw_pos(input int unsigned span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return clamp_pos(window_lo + $urandom_range(0, 511));
      6:       return clamp_pos((span > 2) ? span - 2 + $urandom_range(0, 4)
                                           : $urandom_range(0, 4));
      7:       return clamp_pos($urandom_range(0, POS_TOP));
      8:       return $urandom_range(0, 1) ? POS_W'(POS_TOP) : '0;
      default: return clamp_pos(span + $urandom_range(0, 1000));
    endcase
  endfunction

  // Sender gap, in bursts with and without idling.
  function automatic int unsigned next_gap();
    if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  // start stays high after acceptance so back-to-back items need no gap between them
  task automatic send_item(input cov_cmd_t c, input int unsigned gap, input bit typed,
                           input cov_result_t want);
    cov_result_t pred;
    bit          has_result;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= c.action;
    start_pos_i <= c.first_pos;
    end_pos_i   <= c.last_pos;
    query_pos_i <= c.query_pos;
    do @(posedge clk_i); while (busy);
    has_result = coverage_step(c, pred);
    if (has_result) awaited.insert(awaited.size(), typed ? want : pred);
    case (c.action)
      ACT_ADD:   n_adds++;
      ACT_QUERY: n_queries++;
      ACT_CLEAR: n_clears++;
      default: ;
    endcase
  endtask

  // Register write once the block is idle, then read the genome length back.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    start <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0 || busy);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == GLEN_ADDR) begin
      glen_model = data[GLEN_W-1:0];
      n_lengths++;
    end
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= GLEN_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[GLEN_W-1:0] !== glen_model) begin
      $display("%t: genome_length readback expected %0d, got %0d", $time, glen_model,
               prdata[GLEN_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cov_result_t want;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        $display("%t: result with none awaited: count expected none, got %0d flag %0b",
                 $time, coverage_count_o, out_of_range_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (coverage_count_o !== want.count) begin
          $display("%t: coverage_count expected %0d, got %0d", $time, want.count,
                   coverage_count_o);
          errors++;
        end
        if (out_of_range_o !== want.flag) begin
          $display("%t: out_of_range expected %0b, got %0b", $time, want.flag,
                   out_of_range_o);
          errors++;
        end
        if (out_of_range_o === 1'b1) n_flagged++;
        if (coverage_count_o === {COUNT_W{1'b1}}) n_saturated++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%t: timeout after %0d cycles, %0d results still awaited", $time, cycles,
               awaited.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cov_cmd_t        c;
    int unsigned     r, n_items, span;
    logic [GLEN_W-1:0] len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_reg(DIR_ROWS[i].addr, DIR_ROWS[i].wdata);
      end else begin
        send_item(DIR_ROWS[i].cmd, next_gap(), DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       len = GLEN_W'(32768);
        1:       len = GLEN_W'($urandom_range(16, 300));
        2:       len = GLEN_W'($urandom_range(1000, 32767));
        3:       len = GLEN_W'(1);
        4:       len = '0;
        5:       len = '1;
        6:       len = GLEN_W'(513);
        default: len = GLEN_W'($urandom_range(2, 32767));
      endcase
      n_items = (ph == 3 || ph == 4) ? 40 : 230;
      write_reg(GLEN_ADDR, {16'($urandom), 16'(len)});
      span = positions_used();
      window_lo = (span > 512) ? $urandom_range(0, span - 512) : 0;
      repeat (n_items) begin
        r = $urandom_range(0, 399);
        if (r == 0)        c.action = ACT_CLEAR;
        else if (r <= 4)   c.action = ACT_UNUSED;
        else if (r <= 160) c.action = ACT_QUERY;
        else               c.action = ACT_ADD;
        c.first_pos = draw_pos(span);
        c.query_pos = draw_pos(span);
        case ($urandom_range(0, 19))
          0:       c.last_pos = (c.first_pos > 50)
                                ? POS_W'(c.first_pos - $urandom_range(1, 50)) : '0;
          1:       c.last_pos = clamp_pos(c.first_pos + $urandom_range(0, 2000));
          2:       c.last_pos = ($urandom_range(0, 9) == 0) ? POS_W'(POS_TOP)
                                : clamp_pos(c.first_pos + $urandom_range(0, 200));
          default: c.last_pos = clamp_pos(c.first_pos + $urandom_range(0, 200));
        endcase
        send_item(c, next_gap(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d adds, %0d queries and %0d clears over %0d genome lengths;",
             n_adds, n_queries, n_clears, n_lengths);
    $display("%0d results flagged out of range, %0d saturated counts read back.",
             n_flagged, n_saturated);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ica_pkg.sv
hw/rtl/ica_store.sv
hw/rtl/ica_ctrl.sv
hw/rtl/interval_coverage_accumulator.sv
hw/rtl/ica_checker.sv
test/tb_interval_coverage_accumulator.sv
